// File: hdl/tfn_pkg.sv
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared types and constants for the triangle face normal unit: coordinate
// format and the packed request and result payloads.
// ----------------------------------------------------------------------------
package tfn_pkg;

    // coordinate width and fraction bits of the unit normal
    localparam int COORD_WIDTH = 16;
    localparam int FRAC_BITS   = 14;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] v0_x;
        logic signed [COORD_WIDTH-1:0] v0_y;
        logic signed [COORD_WIDTH-1:0] v0_z;
        logic signed [COORD_WIDTH-1:0] v1_x;
        logic signed [COORD_WIDTH-1:0] v1_y;
        logic signed [COORD_WIDTH-1:0] v1_z;
        logic signed [COORD_WIDTH-1:0] v2_x;
        logic signed [COORD_WIDTH-1:0] v2_y;
        logic signed [COORD_WIDTH-1:0] v2_z;
    } tfn_in_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] normal_x;
        logic signed [COORD_WIDTH-1:0] normal_y;
        logic signed [COORD_WIDTH-1:0] normal_z;
        logic                          degenerate;
    } tfn_out_t;

endpackage

// File: hdl/triangle_face_normal_unit.sv
// ----------------------------------------------------------------------------
// triangle_face_normal_unit
// Unit face normal of a triangle: edge vectors, exact cross product, integer
// square root of the squared length and rounded division of each component.
// ----------------------------------------------------------------------------
// One request carries three vertices in signed Q1.14; one result carries the
// unit normal in signed Q1.14 plus a degenerate flag, which is set (with a
// zero normal) when the cross product vanishes. The unit is a fully pipelined
// datapath that takes a new request every cycle unless stalled and returns
// results in order. It has eight front stages (edges, products, cross,
// magnitude, scale select, scale, squares, sum), one stage per root bit of the
// digit-by-digit square root (RW = 32), one stage that forms the rounded
// numerator, one stage per quotient bit of the three restoring dividers
// (QW = 15) and the output register. The whole pipe advances together
// whenever the output register is empty or its result is being taken, so
// s_ready follows m_ready in the same cycle.
module triangle_face_normal_unit
    import tfn_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  tfn_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output tfn_out_t m_data
);

    // datapath widths
    localparam int CW    = COORD_WIDTH;
    localparam int EW    = CW + 1;             // edge vector component
    localparam int PW    = 2 * EW;             // edge product
    localparam int CRW   = 2 * CW + 2;         // cross component, signed
    localparam int MW    = 2 * CW + 1;         // cross magnitude
    localparam int SMW   = (MW > 31) ? 31 : MW; // scaled magnitude
    localparam int SHMAX = MW - SMW;           // largest scale shift
    localparam int SHW   = (SHMAX > 0) ? $clog2(SHMAX + 1) : 1;
    localparam int SQW   = 2 * SMW;            // square of scaled magnitude
    localparam int SUMW  = 2 * SMW + 2;        // sum of three squares
    localparam int RW    = SMW + 1;            // square root / length
    localparam int QW    = FRAC_BITS + 1;      // quotient, up to 2^FRAC_BITS
    localparam int NW    = SMW + FRAC_BITS + 1; // rounded numerator
    localparam int OW    = (QW + 1 > CW) ? QW + 1 : CW;
    localparam int LAT   = 10 + RW + QW;

    // pipeline control: one valid bit per stage, whole pipe moves together
    logic [LAT-1:0] vld_reg;
    logic           adv;

    assign adv     = !vld_reg[LAT-1] || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
        end
    end

    // request fields as an array: v0 xyz, v1 xyz, v2 xyz
    logic signed [CW-1:0] pv [9];

    assign pv[0] = s_data.v0_x;
    assign pv[1] = s_data.v0_y;
    assign pv[2] = s_data.v0_z;
    assign pv[3] = s_data.v1_x;
    assign pv[4] = s_data.v1_y;
    assign pv[5] = s_data.v1_z;
    assign pv[6] = s_data.v2_x;
    assign pv[7] = s_data.v2_y;
    assign pv[8] = s_data.v2_z;

    // stage 1: edge vectors e1 = v1 - v0, e2 = v2 - v0
    logic signed [EW-1:0] e1_reg [3];
    logic signed [EW-1:0] e2_reg [3];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                e1_reg[i] <= EW'(pv[3+i]) - EW'(pv[i]);
                e2_reg[i] <= EW'(pv[6+i]) - EW'(pv[i]);
            end
        end
    end

    // stage 2: the edge products, a pair for each cross component
    logic signed [PW-1:0] prod_reg [6];

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg[0] <= PW'(e1_reg[1]) * PW'(e2_reg[2]);
            prod_reg[1] <= PW'(e2_reg[1]) * PW'(e1_reg[2]);
            prod_reg[2] <= PW'(e1_reg[2]) * PW'(e2_reg[0]);
            prod_reg[3] <= PW'(e2_reg[2]) * PW'(e1_reg[0]);
            prod_reg[4] <= PW'(e1_reg[0]) * PW'(e2_reg[1]);
            prod_reg[5] <= PW'(e2_reg[0]) * PW'(e1_reg[1]);
        end
    end

    // stage 3: exact cross product
    logic signed [CRW-1:0] c_reg [3];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                c_reg[i] <= CRW'(prod_reg[2*i]) - CRW'(prod_reg[2*i+1]);
            end
        end
    end

    // stage 4: sign and magnitude, zero cross product flag
    logic [MW-1:0] mag_reg [3];
    logic [2:0]    sg4_reg;
    logic          dg4_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                sg4_reg[i] <= c_reg[i][CRW-1];
                mag_reg[i] <= c_reg[i][CRW-1] ? MW'(-c_reg[i]) : MW'(c_reg[i]);
            end
            dg4_reg <= (c_reg[0] == '0) && (c_reg[1] == '0) && (c_reg[2] == '0);
        end
    end

    // stage 5: smallest shift that brings the largest magnitude below 2^31
    logic [SHW-1:0] sh_next;
    logic [SHW-1:0] sh_reg;
    logic [MW-1:0]  mag5_reg [3];
    logic [2:0]     sg5_reg;
    logic           dg5_reg;

    always_comb begin
        sh_next = '0;
        for (int k = 0; k < SHMAX; k++) begin
            if ((mag_reg[0] >> (31 + k)) != '0 || (mag_reg[1] >> (31 + k)) != '0 ||
                (mag_reg[2] >> (31 + k)) != '0) begin
                sh_next = sh_next + SHW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sh_reg   <= sh_next;
            mag5_reg <= mag_reg;
            sg5_reg  <= sg4_reg;
            dg5_reg  <= dg4_reg;
        end
    end

    // stage 6: scaled magnitudes
    logic [SMW-1:0] msh_reg [3];
    logic [2:0]     sg6_reg;
    logic           dg6_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                msh_reg[i] <= SMW'(mag5_reg[i] >> sh_reg);
            end
            sg6_reg <= sg5_reg;
            dg6_reg <= dg5_reg;
        end
    end

    // stage 7: squares
    logic [SQW-1:0] sq_reg  [3];
    logic [SMW-1:0] msh7_reg [3];
    logic [2:0]     sg7_reg;
    logic           dg7_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= SQW'(msh_reg[i]) * SQW'(msh_reg[i]);
            end
            msh7_reg <= msh_reg;
            sg7_reg  <= sg6_reg;
            dg7_reg  <= dg6_reg;
        end
    end

    // square root pipe; entry 0 is the sum stage, entry j has j root bits
    logic [RW:0]     rem_reg  [RW+1];
    logic [RW-1:0]   root_reg [RW+1];
    logic [SUMW-1:0] nr_reg   [RW+1];
    logic [SMW-1:0]  mq_reg   [RW+1][3];
    logic [2:0]      sgq_reg  [RW+1];
    logic            dgq_reg  [RW+1];

    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            nr_reg[0]   <= SUMW'(sq_reg[0]) + SUMW'(sq_reg[1]) + SUMW'(sq_reg[2]);
            mq_reg[0]   <= msh7_reg;
            sgq_reg[0]  <= sg7_reg;
            dgq_reg[0]  <= dg7_reg;
        end
    end

    for (genvar j = 1; j <= RW; j++) begin : g_sqrt
        logic [RW+2:0] cur;
        logic [RW+2:0] trial;
        logic          ge;

        // bring down the next two radicand bits, try root*4 + 1
        assign cur   = {rem_reg[j-1], nr_reg[j-1][SUMW-1 -: 2]};
        assign trial = (RW+3)'({root_reg[j-1], 2'b01});
        assign ge    = cur >= trial;

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[j]  <= ge ? (RW+1)'(cur - trial) : (RW+1)'(cur);
                root_reg[j] <= {root_reg[j-1][RW-2:0], ge};
                nr_reg[j]   <= nr_reg[j-1] << 2;
                mq_reg[j]   <= mq_reg[j-1];
                sgq_reg[j]  <= sgq_reg[j-1];
                dgq_reg[j]  <= dgq_reg[j-1];
            end
        end
    end

    // divider pipe; entry 0 forms m * 2^FRAC_BITS + len / 2 and splits it
    logic [NW-1:0]   num   [3];
    logic [RW-1:0]   len;
    logic [RW-1:0]   dr_reg  [QW+1][3];
    logic [QW-1:0]   dn_reg  [QW+1][3];
    logic [RW-1:0]   len_reg [QW+1];
    logic [2:0]      sgd_reg [QW+1];
    logic            dgd_reg [QW+1];

    assign len = root_reg[RW];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            num[i] = (NW'(mq_reg[RW][i]) << FRAC_BITS) + NW'(len >> 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                dr_reg[0][i] <= RW'(num[i] >> QW);
                dn_reg[0][i] <= num[i][QW-1:0];
            end
            len_reg[0] <= len;
            sgd_reg[0] <= sgq_reg[RW];
            dgd_reg[0] <= dgq_reg[RW];
        end
    end

    for (genvar j = 1; j <= QW; j++) begin : g_div
        for (genvar i = 0; i < 3; i++) begin : g_lane
            logic [RW:0] cur;
            logic        ge;

            // restoring step: quotient bits shift in as numerator bits leave
            assign cur = {dr_reg[j-1][i], dn_reg[j-1][i][QW-1]};
            assign ge  = cur >= (RW+1)'(len_reg[j-1]);

            always_ff @(posedge aclk) begin
                if (adv) begin
                    dr_reg[j][i] <= ge ? RW'(cur - (RW+1)'(len_reg[j-1])) : RW'(cur);
                    dn_reg[j][i] <= {dn_reg[j-1][i][QW-2:0], ge};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                len_reg[j] <= len_reg[j-1];
                sgd_reg[j] <= sgd_reg[j-1];
                dgd_reg[j] <= dgd_reg[j-1];
            end
        end
    end

    // output stage: restore signs, force zero normal on degenerate triangle
    logic signed [OW-1:0] sval [3];
    tfn_out_t             out_next;
    tfn_out_t             out_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sval[i] = sgd_reg[QW][i] ? -$signed(OW'(dn_reg[QW][i]))
                                     : $signed(OW'(dn_reg[QW][i]));
        end
        out_next.degenerate = dgd_reg[QW];
        out_next.normal_x   = dgd_reg[QW] ? '0 : sval[0][CW-1:0];
        out_next.normal_y   = dgd_reg[QW] ? '0 : sval[1][CW-1:0];
        out_next.normal_z   = dgd_reg[QW] ? '0 : sval[2][CW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

`ifndef SYNTHESIS
    // degenerate results always carry a zero normal
    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.degenerate |->
            m_data.normal_x == '0 && m_data.normal_y == '0 && m_data.normal_z == '0)
        else $error("degenerate result with nonzero normal");

    // the length is never below any scaled component
    a_root_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[7+RW] && !dgq_reg[RW] |->
            RW'(mq_reg[RW][0]) <= root_reg[RW] && RW'(mq_reg[RW][1]) <= root_reg[RW] &&
            RW'(mq_reg[RW][2]) <= root_reg[RW])
        else $error("square root below component magnitude");

    // quotients stay within one unit
    a_quot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[8+RW+QW] && !dgd_reg[QW] |->
            dn_reg[QW][0] <= (QW'(1) << FRAC_BITS) && dn_reg[QW][1] <= (QW'(1) << FRAC_BITS) &&
            dn_reg[QW][2] <= (QW'(1) << FRAC_BITS))
        else $error("normal component above one");

    // a stall freezes every stage
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved during stall");
`endif

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the triangle face normal unit: a directed table of
// triangles followed by random ones, each checked against a fixed expectation
// or an in-bench model, with random idling on both sides for most of the run.
// ----------------------------------------------------------------------------
module tb;
    import tfn_pkg::*;

    localparam int LATENCY   = 57;
    localparam int N_RANDOM  = 1130;
    localparam int MAX_CYCLE = 400000;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    tfn_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    tfn_out_t m_data;

    // expected normals waiting for their result, oldest first
    tfn_out_t normal_q[$];
    int       n_errors;
    int       cycle_cnt;
    // percent chance per cycle that sender / receiver idles
    int       send_idle_pct;
    int       recv_idle_pct;

    // directed row: request, and an expected result where it is obvious
    typedef struct {
        tfn_in_t  face;
        bit       has_fixed;
        tfn_out_t fixed;
    } tri_row_t;

    triangle_face_normal_unit u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 10 ns clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // bit-serial integer square root of a 64-bit value
    function automatic logic [63:0] isqrt(input logic [63:0] n);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n    = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // unit face normal of one triangle
    function automatic tfn_out_t face_normal(input tfn_in_t t);
        tfn_out_t         r;
        logic signed [63:0] e1 [3];
        logic signed [63:0] e2 [3];
        logic signed [63:0] c [3];
        logic [63:0]      mg [3];
        logic [63:0]      mx, sum, len, q;
        int               sh;
        e1[0] = 64'(t.v1_x) - 64'(t.v0_x);
        e1[1] = 64'(t.v1_y) - 64'(t.v0_y);
        e1[2] = 64'(t.v1_z) - 64'(t.v0_z);
        e2[0] = 64'(t.v2_x) - 64'(t.v0_x);
        e2[1] = 64'(t.v2_y) - 64'(t.v0_y);
        e2[2] = 64'(t.v2_z) - 64'(t.v0_z);
        c[0] = e1[1] * e2[2] - e2[1] * e1[2];
        c[1] = e1[2] * e2[0] - e2[2] * e1[0];
        c[2] = e1[0] * e2[1] - e2[0] * e1[1];
        r = '0;
        if (c[0] == 0 && c[1] == 0 && c[2] == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            mg[i] = c[i] < 0 ? -c[i] : c[i];
            if (mg[i] > mx) mx = mg[i];
        end
        sh = 0;
        while (sh < 63 && (mx >> sh) >= (64'd1 << 31)) sh++;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            mg[i] = mg[i] >> sh;
            sum   = sum + mg[i] * mg[i];
        end
        len = isqrt(sum);
        if (len == 0) len = 1;
        for (int i = 0; i < 3; i++) begin
            q = ((mg[i] << FRAC_BITS) + (len >> 1)) / len;
            if (c[i] < 0) q = -q;
            case (i)
                0: r.normal_x = q[COORD_WIDTH-1:0];
                1: r.normal_y = q[COORD_WIDTH-1:0];
                default: r.normal_z = q[COORD_WIDTH-1:0];
            endcase
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, exp,
                 cycle_cnt);
        n_errors++;
    endtask

    // timeout watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > MAX_CYCLE) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // result side: random stall and check against oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (normal_q.size() == 0) begin
                report_mismatch("unexpected result", 32'(m_data), 0);
            end else begin
                tfn_out_t e;
                e = normal_q.pop_front();
                if (m_data.normal_x !== e.normal_x)
                    report_mismatch("normal_x", 32'(m_data.normal_x), 32'(e.normal_x));
                if (m_data.normal_y !== e.normal_y)
                    report_mismatch("normal_y", 32'(m_data.normal_y), 32'(e.normal_y));
                if (m_data.normal_z !== e.normal_z)
                    report_mismatch("normal_z", 32'(m_data.normal_z), 32'(e.normal_z));
                if (m_data.degenerate !== e.degenerate)
                    report_mismatch("degenerate", 32'(m_data.degenerate),
                                    32'(e.degenerate));
            end
        end
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // offer one request, waiting out random idle cycles first
    task automatic send_tri(input tfn_in_t t, input tfn_out_t exp);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= t;
        normal_q = {normal_q, exp};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_coord(input int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(200)) - 100);
            default: return $urandom_range(1) ? 16'h8000 : 16'h7fff;
        endcase
    endfunction

    tri_row_t dir_rows[$];

    function automatic tfn_in_t mk(input int a0, a1, a2, b0, b1, b2, d0, d1, d2);
        tfn_in_t t;
        t = {16'(a0), 16'(a1), 16'(a2), 16'(b0), 16'(b1), 16'(b2),
             16'(d0), 16'(d1), 16'(d2)};
        return t;
    endfunction

    task automatic add_row(input tfn_in_t t, input bit fx, input tfn_out_t f);
        tri_row_t row;
        row.face = t;
        row.has_fixed = fx;
        row.fixed = f;
        dir_rows = {dir_rows, row};
    endtask

    initial begin
        tfn_out_t zero_deg, z_up, z_down, x_up;
        tfn_in_t  t;
        int       mode;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        m_ready       = 1'b0;
        n_errors      = 0;
        cycle_cnt     = 0;
        send_idle_pct = 9;
        recv_idle_pct = 87;
        zero_deg = '{16'sd0, 16'sd0, 16'sd0, 1'b1};
        z_up     = '{16'sd0, 16'sd0, 16'sd16384, 1'b0};
        z_down   = '{16'sd0, 16'sd0, -16'sd16384, 1'b0};
        x_up     = '{16'sd16384, 16'sd0, 16'sd0, 1'b0};

        // directed triangles
        add_row('0, 1, zero_deg);                                   // all zero
        add_row(mk(5, 5, 5, 5, 5, 5, 5, 5, 5), 1, zero_deg);        // coincident
        add_row(mk(0, 0, 0, 1, 1, 1, 2, 2, 2), 1, zero_deg);        // collinear
        add_row(mk(0, 0, 0, 16384, 0, 0, 0, 16384, 0), 1, z_up);
        add_row(mk(0, 0, 0, 0, 16384, 0, 16384, 0, 0), 1, z_down);
        add_row(mk(0, 0, 0, 0, 1, 0, 0, 0, 1), 1, x_up);
        add_row(mk(-32768, -32768, -32768, 32767, -32768, -32768,
                   -32768, 32767, -32768), 1, z_up);                // widest edges
        add_row(mk(32767, 32767, 32767, -32768, 32767, 32767,
                   32767, -32768, 32767), 1, z_up);
        add_row(mk(-32768, -32768, -32768, 32767, 32767, -32768,
                   -32768, 32767, 32767), 0, zero_deg);             // shifted length
        add_row(mk(32767, -32768, 0, -32768, 32767, 32767,
                   0, 32767, -32768), 0, zero_deg);
        add_row(mk(0, 0, 0, 1, 0, 0, 1, 1, 1), 0, zero_deg);
        add_row(mk(0, 0, 0, 3, 4, 0, -4, 3, 7), 0, zero_deg);
        add_row(mk(-1, -1, -1, -1, -1, -1, 0, 0, 0), 1, zero_deg);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i])
            send_tri(dir_rows[i].face,
                     dir_rows[i].has_fixed ? dir_rows[i].fixed : face_normal(dir_rows[i].face));

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 3) begin
                send_idle_pct = 87;
                recv_idle_pct = 9;
            end
            if (n == 2 * N_RANDOM / 3) begin
                // let the pipe drain completely once
                s_valid <= 1'b0;
                while (normal_q.size() != 0) @(posedge aclk);
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            mode = $urandom_range(9);
            for (int k = 0; k < 9; k++)
                t[16*k +: 16] = rand_coord(mode < 6 ? 0 : (mode < 9 ? 1 : 2));
            if ($urandom_range(19) == 0) begin
                t.v1_x = t.v0_x; t.v1_y = t.v0_y; t.v1_z = t.v0_z;   // degenerate
            end
            send_tri(t, face_normal(t));
        end
        s_valid <= 1'b0;

        while (normal_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        if (n_errors == 0 && normal_q.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
